### rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset execute unit package
// Shared types, opcodes and widths for the execute unit and its submodules.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned NumRegs    = 32;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned XLen       = 32;
  localparam int unsigned InDataW    = 40;   // instr_word, reg_index, pad
  localparam int unsigned OutDataW   = 104;  // all result fields, pad

  localparam logic [XLen-1:0] TextBaseReset = 32'h0040_0000;
  localparam logic [RegIdxW-1:0] LinkReg     = 5'd31;
  localparam logic [RegIdxW-1:0] ZeroReg     = 5'd0;

  // Primary opcodes.
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAndi    = 6'h0C;

  // Function codes under the special opcode.
  localparam logic [5:0] FnSll = 6'h00;
  localparam logic [5:0] FnSrl = 6'h02;
  localparam logic [5:0] FnJr  = 6'h08;
  localparam logic [5:0] FnAdd = 6'h20;

  // Request kinds carried on the input tuser bit.
  localparam logic ReqExec = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [XLen-1:0]    val;
  } reg_wr_t;

  typedef struct packed {
    logic [XLen-1:0] read_value;
    reg_wr_t         wr;
    logic            halt;
    logic [XLen-1:0] next_pc;
  } exec_res_t;

endpackage

### rtl/core/mse_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset register file
// 32 x 32 storage with two registered read ports, write bypass and
// per-entry valid bits so that unwritten registers read as zero.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [mse_pkg::RegIdxW-1:0]   rd_addr_a_i,
  input  logic [mse_pkg::RegIdxW-1:0]   rd_addr_b_i,
  input  mse_pkg::reg_wr_t              wr_i,
  output logic [mse_pkg::XLen-1:0]      rd_data_a_o,
  output logic [mse_pkg::XLen-1:0]      rd_data_b_o
);
  import mse_pkg::*;

  logic [XLen-1:0]    mem [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [XLen-1:0]    rd_a_q;
  logic [XLen-1:0]    rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.val;
    end
  end

  // A write landing in the same cycle is forwarded to the reader.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.idx == rd_addr_a_i)) begin
        rd_a_q <= wr_i.val;
      end else begin
        rd_a_q <= valid_q[rd_addr_a_i] ? mem[rd_addr_a_i] : '0;
      end
      if (wr_i.en && (wr_i.idx == rd_addr_b_i)) begin
        rd_b_q <= wr_i.val;
      end else begin
        rd_b_q <= valid_q[rd_addr_b_i] ? mem[rd_addr_b_i] : '0;
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

### rtl/core/mse_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset execute logic
// Decodes one instruction or serves a read; computes write-back and next pc.
// ----------------------------------------------------------------------------
module mse_exec (
  input  logic                      req_i,
  input  logic [mse_pkg::XLen-1:0]  instr_i,
  input  logic [mse_pkg::XLen-1:0]  pc_i,
  input  logic [mse_pkg::XLen-1:0]  rs_val_i,
  input  logic [mse_pkg::XLen-1:0]  rt_val_i,
  output mse_pkg::exec_res_t        res_o
);
  import mse_pkg::*;

  logic [5:0]         opc;
  logic [5:0]         fn;
  logic [RegIdxW-1:0] rt;
  logic [RegIdxW-1:0] rd;
  logic [4:0]         sh;
  logic [XLen-1:0]    imm_sx;
  logic [XLen-1:0]    imm_zx;
  logic [XLen-1:0]    pc_plus4;
  logic [XLen-1:0]    br_target;
  reg_wr_t            wr;

  assign opc       = instr_i[31:26];
  assign rt        = instr_i[20:16];
  assign rd        = instr_i[15:11];
  assign sh        = instr_i[10:6];
  assign fn        = instr_i[5:0];
  assign imm_sx    = {{16{instr_i[15]}}, instr_i[15:0]};
  assign imm_zx    = {16'h0000, instr_i[15:0]};
  assign pc_plus4  = pc_i + 32'd4;
  assign br_target = pc_plus4 + {imm_sx[29:0], 2'b00};

  always_comb begin
    res_o            = '0;
    res_o.next_pc    = pc_plus4;
    wr               = '0;
    if (req_i == ReqRead) begin
      res_o.next_pc    = pc_i;
      res_o.read_value = rs_val_i;
    end else if (instr_i == '0) begin
      res_o.next_pc = pc_i;
      res_o.halt    = 1'b1;
    end else begin
      unique case (opc)
        OpSpecial: begin
          unique case (fn)
            FnAdd: wr = '{en: 1'b1, idx: rd, val: rs_val_i + rt_val_i};
            FnSll: wr = '{en: 1'b1, idx: rd, val: rt_val_i << sh};
            FnSrl: wr = '{en: 1'b1, idx: rd, val: rt_val_i >> sh};
            FnJr:  res_o.next_pc = rs_val_i;
            default: ;
          endcase
        end
        OpAddi: wr = '{en: 1'b1, idx: rt, val: rs_val_i + imm_sx};
        OpAndi: wr = '{en: 1'b1, idx: rt, val: rs_val_i & imm_zx};
        OpBlez: begin
          if ((rs_val_i == '0) || rs_val_i[XLen-1]) begin
            res_o.next_pc = br_target;
          end
        end
        OpBne: begin
          if (rs_val_i != rt_val_i) begin
            res_o.next_pc = br_target;
          end
        end
        OpJal: begin
          wr            = '{en: 1'b1, idx: LinkReg, val: pc_plus4};
          res_o.next_pc = {pc_i[31:28], instr_i[25:0], 2'b00};
        end
        default: ;
      endcase
      // Register zero is hardwired; a write to it is dropped entirely.
      if (wr.en && (wr.idx != ZeroReg)) begin
        res_o.wr = wr;
      end
    end
  end

endmodule

### rtl/core/mips_subset_execute_unit.sv
`timescale 1ns / 1ps
// Timing: the input register loads at the input transfer, and the result register
// when the item leaves the input stage. Throughput: one item per cycle while the
// output is not stalled; a register written by one instruction is forwarded into
// the operand read of the next, so dependent items go back to back.
// Reset: asynchronous, active low; clears the register file valid bits and
// both pipeline valid flags, and loads the program counter with 0x00400000.
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// Executes one instruction word or serves one register read per transfer,
// holding a 32-entry register file and the program counter.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: text_base write, which loads the program counter.
  input  logic                           cfg_we_i,
  input  logic [mse_pkg::XLen-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] instr_word, [36:32] reg_index, [39:37] zero.
  input  logic [mse_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] req_type.
  input  logic                           s_axis_tuser,
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] next_pc, [32] halt, [33] reg_write, [38:34] write_index,
  // [70:39] write_value, [102:71] read_value, [103] zero.
  output logic [mse_pkg::OutDataW-1:0]   m_axis_tdata
);
  import mse_pkg::*;

  // The input stage holds the accepted request together with its operands,
  // which the register file reads at the transfer edge. The result stage
  // holds the finished result until the downstream side takes it.
  logic              a_valid_q;
  logic              a_req_q;
  logic [XLen-1:0]   a_instr_q;
  logic              res_valid_q;
  exec_res_t         res_q;
  logic [XLen-1:0]   pc_q;

  logic              in_xfer;
  logic              advance;
  logic [XLen-1:0]   rs_val;
  logic [XLen-1:0]   rt_val;
  logic [RegIdxW-1:0] rd_addr_a;
  exec_res_t         exec_res;
  reg_wr_t           rf_wr;

  // The item in the input stage moves on whenever the result stage is empty
  // or is being emptied in this cycle; the input side is open whenever the
  // input stage is empty or moving on.
  assign advance       = a_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // A read request uses port A for its register; an instruction uses it for rs.
  assign rd_addr_a = (s_axis_tuser == ReqRead) ? s_axis_tdata[36:32] : s_axis_tdata[25:21];

  // State changes commit only when the instruction leaves the input stage,
  // so a stalled item never writes twice.
  always_comb begin
    rf_wr    = exec_res.wr;
    rf_wr.en = exec_res.wr.en && advance;
  end

  mse_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_xfer),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (s_axis_tdata[20:16]),
    .wr_i        (rf_wr),
    .rd_data_a_o (rs_val),
    .rd_data_b_o (rt_val)
  );

  mse_exec u_exec (
    .req_i    (a_req_q),
    .instr_i  (a_instr_q),
    .pc_i     (pc_q),
    .rs_val_i (rs_val),
    .rt_val_i (rt_val),
    .res_o    (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_req_q   <= s_axis_tuser;
      a_instr_q <= s_axis_tdata[31:0];
    end
  end

  // The program counter follows each executed item; a configuration write
  // reloads it and must come only while the unit is idle, which is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= TextBaseReset;
    end else if (cfg_we_i) begin
      pc_q <= cfg_wdata_i;
    end else if (advance) begin
      pc_q <= exec_res.next_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= exec_res;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.read_value, res_q.wr.val, res_q.wr.idx,
                          res_q.wr.en, res_q.halt, res_q.next_pc};

endmodule

### rtl/core/mse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset execute unit checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module mse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mse_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mse_pkg::*;

  logic out_xfer;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // With no result waiting, the pipeline can always take an item.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // A halt directly after another result leaves the pc where it was.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && m_axis_tdata[32]) |->
      (m_axis_tdata[31:0] == $past(m_axis_tdata[31:0])))
    else $error("halt moved the program counter");

  // Register zero is never reported as written.
  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[38:34] != ZeroReg))
    else $error("write to register zero reported");

  // A halt writes nothing.
  a_halt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[32]) |-> !m_axis_tdata[33])
    else $error("halt with register write");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (.*);
